[hdl/life_like_cellular_automaton_macros.svh]
`ifndef LIFE_LIKE_CELLULAR_AUTOMATON_MACROS_SVH
`define LIFE_LIKE_CELLULAR_AUTOMATON_MACROS_SVH

// Check that cons holds in the same cycle as ante; the module must have clk and rst_n.
`define LLCA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define LLCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/llca_pkg.sv]
`timescale 1ns / 1ps

package llca_pkg;

    // Grid store dimensions
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // Field and register widths
    localparam int DIM_W  = 7;
    localparam int CNT_W  = 4;
    localparam int GEN_W  = 16;
    localparam int POS_W  = 6;
    localparam int FUNC_W = 2;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    // Item function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RUN  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_GRID_ROWS    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_GRID_COLS    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_BIRTH_COUNT  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_SURVIVE_LOW  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_SURVIVE_HIGH = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_GENERATIONS  = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ITEM_WR,
        S_RUN_PRIME,
        S_RUN_CAP,
        S_ROW_RD,
        S_ROW_CALC,
        S_RESULT
    } llca_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic rd_item;
        logic wr_item;
        logic gen_clr;
        logic prime_rd;
        logic prime_cap;
        logic row_rd;
        logic row_calc;
        logic gen_inc;
        logic res_en;
    } llca_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              in_grid;
        logic              run_empty;
        logic              last_row;
        logic              gen_last;
        logic              changed;
    } llca_status_t;

endpackage

[hdl/llca_ctrl.sv]
`timescale 1ns / 1ps

`include "life_like_cellular_automaton_macros.svh"

module llca_ctrl
    import llca_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  llca_status_t status,
    output logic         busy,
    output llca_cmd_t    cmd
);

    llca_state_t state_reg;
    llca_state_t state_next;

    // Hold the state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence items and the generation sweep
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.func)
                    FUNC_LOAD:
                    begin
                        cmd.rd_item = 1'b1;
                        state_next  = status.in_grid ? S_ITEM_WR : S_RESULT;
                    end
                    FUNC_READ:
                    begin
                        cmd.rd_item = 1'b1;
                        state_next  = S_RESULT;
                    end
                    FUNC_RUN:
                    begin
                        if (status.run_empty)
                        begin
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            cmd.gen_clr = 1'b1;
                            state_next  = S_RUN_PRIME;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_ITEM_WR:
            begin
                cmd.wr_item = 1'b1;
                state_next  = S_RESULT;
            end
            S_RUN_PRIME:
            begin
                cmd.prime_rd = 1'b1;
                state_next   = S_RUN_CAP;
            end
            S_RUN_CAP:
            begin
                cmd.prime_cap = 1'b1;
                state_next    = S_ROW_RD;
            end
            S_ROW_RD:
            begin
                cmd.row_rd = 1'b1;
                state_next = S_ROW_CALC;
            end
            S_ROW_CALC:
            begin
                cmd.row_calc = 1'b1;
                if (!status.last_row)
                begin
                    state_next = S_ROW_RD;
                end
                else if (status.gen_last || !status.changed)
                begin
                    // stop on the last generation or on a fixed point
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.gen_inc = 1'b1;
                    state_next  = S_RUN_PRIME;
                end
            end
            S_RESULT:
            begin
                cmd.res_en = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    `LLCA_ASSERT_NEXT(a_start_decodes, (state_reg == S_IDLE) && start,
        state_reg == S_DECODE, "accepted item did not reach decode")
    `LLCA_ASSERT_NEXT(a_result_returns, state_reg == S_RESULT,
        state_reg == S_IDLE, "result state did not return to idle")
    `LLCA_ASSERT_IMPLY(a_calc_after_read, state_reg == S_ROW_CALC,
        $past(state_reg) == S_ROW_RD, "row update without a preceding row read")

endmodule

[hdl/llca_datapath.sv]
`timescale 1ns / 1ps

module llca_datapath
    import llca_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    input  logic [FUNC_W-1:0] func,
    input  logic [POS_W-1:0]  row,
    input  logic [POS_W-1:0]  col,
    input  logic              cell_in,
    input  llca_cmd_t         cmd,
    output llca_status_t      status,
    output logic              valid,
    output logic              cell_out,
    output logic              done_res
);

    // Configuration registers
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    logic [CNT_W-1:0] birth_reg;
    logic [CNT_W-1:0] slo_reg;
    logic [CNT_W-1:0] shi_reg;
    logic [GEN_W-1:0] gens_reg;

    // Item registers
    logic [FUNC_W-1:0] func_reg;
    logic [POS_W-1:0]  row_reg;
    logic [POS_W-1:0]  col_reg;
    logic              cell_reg;

    // Grid store, one word per row
    logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] row_valid_reg;
    logic [MAX_COLS-1:0] rd_raw_reg;
    logic                rd_valid_reg;
    logic [MAX_COLS-1:0] rd_data;
    logic                rd_en;
    logic [ROW_AW-1:0]   rd_addr;
    logic                wr_en;
    logic [ROW_AW-1:0]   wr_addr;
    logic [MAX_COLS-1:0] wr_data;

    // Sweep registers
    logic [MAX_COLS-1:0] prev_reg;
    logic [MAX_COLS-1:0] cur_reg;
    logic                nxt_ok_reg;
    logic [DIM_W-1:0]    row_cnt_reg;
    logic [GEN_W-1:0]    gen_cnt_reg;
    logic                changed_reg;

    // Result registers
    logic valid_reg;
    logic cell_out_reg;
    logic done_res_reg;

    logic [DIM_W-1:0]    nr;
    logic [DIM_W-1:0]    nc;
    logic [DIM_W-1:0]    row_plus;
    logic                in_grid;
    logic [MAX_COLS-1:0] col_mask;
    logic [MAX_COLS-1:0] nxt_row;
    logic [MAX_COLS-1:0] new_row;
    logic [MAX_COLS-1:0] item_row;
    logic                row_diff;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= DIM_W'(64);
            cols_reg  <= DIM_W'(64);
            birth_reg <= CNT_W'(3);
            slo_reg   <= CNT_W'(2);
            shi_reg   <= CNT_W'(4);
            gens_reg  <= GEN_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_GRID_ROWS:    rows_reg  <= cfg_wdata[DIM_W-1:0];
                CFG_GRID_COLS:    cols_reg  <= cfg_wdata[DIM_W-1:0];
                CFG_BIRTH_COUNT:  birth_reg <= cfg_wdata[CNT_W-1:0];
                CFG_SURVIVE_LOW:  slo_reg   <= cfg_wdata[CNT_W-1:0];
                CFG_SURVIVE_HIGH: shi_reg   <= cfg_wdata[CNT_W-1:0];
                CFG_GENERATIONS:  gens_reg  <= cfg_wdata[GEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Capture the item on transfer
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            row_reg  <= row;
            col_reg  <= col;
            cell_reg <= cell_in;
        end
    end

    // Clamp the grid in use to the store
    assign nr = (rows_reg > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_reg;
    assign nc = (cols_reg > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_reg;
    assign in_grid = (DIM_W'(row_reg) < nr) && (DIM_W'(col_reg) < nc);
    assign row_plus = row_cnt_reg + DIM_W'(1);

    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            col_mask[c] = (DIM_W'(c) < nc);
        end
    end

    // Select memory addresses and write data
    assign rd_en   = cmd.rd_item | cmd.prime_rd | cmd.row_rd;
    assign rd_addr = cmd.rd_item ? row_reg[ROW_AW-1:0] :
                     cmd.row_rd  ? row_plus[ROW_AW-1:0] : '0;
    assign wr_en   = cmd.wr_item | cmd.row_calc;
    assign wr_addr = cmd.wr_item ? row_reg[ROW_AW-1:0] : row_cnt_reg[ROW_AW-1:0];
    assign wr_data = cmd.wr_item ? item_row : new_row;

    always_comb
    begin
        item_row = rd_data;
        item_row[col_reg[COL_AW-1:0]] = cell_reg;
    end

    // Grid memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            grid_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= grid_mem[rd_addr];
        end
    end

    // Track rows written since reset; unwritten rows read as dead
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;
    assign nxt_row = nxt_ok_reg ? rd_data : '0;

    // Apply the rule to one whole row from its three-row window
    always_comb
    begin
        logic [MAX_COLS+1:0] pe;
        logic [MAX_COLS+1:0] ce;
        logic [MAX_COLS+1:0] ne;
        logic [CNT_W-1:0]    cnt;
        logic                next_cell;
        pe = {1'b0, prev_reg & col_mask, 1'b0};
        ce = {1'b0, cur_reg & col_mask, 1'b0};
        ne = {1'b0, nxt_row & col_mask, 1'b0};
        for (int c = 0; c < MAX_COLS; c++)
        begin
            cnt = CNT_W'(pe[c]) + CNT_W'(pe[c+1]) + CNT_W'(pe[c+2])
                + CNT_W'(ce[c]) + CNT_W'(ce[c+2])
                + CNT_W'(ne[c]) + CNT_W'(ne[c+1]) + CNT_W'(ne[c+2]);
            if (ce[c+1])
            begin
                next_cell = (cnt >= slo_reg) && (cnt < shi_reg);
            end
            else
            begin
                next_cell = (cnt == birth_reg);
            end
            new_row[c] = col_mask[c] ? next_cell : cur_reg[c];
        end
    end

    assign row_diff = (new_row != cur_reg);

    // Advance the row window and counters
    always_ff @(posedge clk)
    begin
        if (cmd.prime_rd)
        begin
            prev_reg <= '0;
        end
        else if (cmd.row_calc)
        begin
            prev_reg <= cur_reg;
        end
        if (cmd.prime_cap)
        begin
            cur_reg <= rd_data;
        end
        else if (cmd.row_calc)
        begin
            cur_reg <= nxt_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nxt_ok_reg  <= 1'b0;
            row_cnt_reg <= '0;
            gen_cnt_reg <= '0;
            changed_reg <= 1'b0;
        end
        else
        begin
            if (cmd.row_rd)
            begin
                nxt_ok_reg <= (row_plus < nr);
            end
            if (cmd.prime_rd)
            begin
                row_cnt_reg <= '0;
                changed_reg <= 1'b0;
            end
            else if (cmd.row_calc)
            begin
                row_cnt_reg <= row_plus;
                changed_reg <= changed_reg | row_diff;
            end
            if (cmd.gen_clr)
            begin
                gen_cnt_reg <= '0;
            end
            else if (cmd.gen_inc)
            begin
                gen_cnt_reg <= gen_cnt_reg + GEN_W'(1);
            end
        end
    end

    // Report status
    assign status.func      = func_reg;
    assign status.in_grid   = in_grid;
    assign status.run_empty = (nr == '0) || (nc == '0) || (gens_reg == '0);
    assign status.last_row  = (row_plus == nr);
    assign status.gen_last  = ({1'b0, gen_cnt_reg} + (GEN_W+1)'(1)) == {1'b0, gens_reg};
    assign status.changed   = changed_reg | row_diff;

    // Form the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.res_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_en)
        begin
            cell_out_reg <= (func_reg == FUNC_READ) && in_grid && rd_data[col_reg[COL_AW-1:0]];
            done_res_reg <= (func_reg == FUNC_RUN)
                         || (((func_reg == FUNC_LOAD) || (func_reg == FUNC_READ)) && in_grid);
        end
    end

    assign valid    = valid_reg;
    assign cell_out = cell_out_reg;
    assign done_res = done_res_reg;

endmodule

[hdl/life_like_cellular_automaton.sv]
// From transfer to result strobe: a read passes decode and result, a load decode, item
// write and result, an ignored item decode and result. A run primes the row window for
// each generation, reads and rewrites each row in use, and stops early at a fixed point.
// One item at a time; the next is taken in the cycle the previous result is shown.
// Reset clears the grid to all dead and loads the register defaults; no clearing pass.
`timescale 1ns / 1ps

module life_like_cellular_automaton
    import llca_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    input  logic              start,
    input  logic [FUNC_W-1:0] func,
    input  logic [POS_W-1:0]  row,
    input  logic [POS_W-1:0]  col,
    input  logic              cell_in,
    output logic              busy,
    output logic              valid,
    output logic              cell_out,
    output logic              done_res
);

    llca_cmd_t    cmd;
    llca_status_t status;

    // Sequence items
    llca_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // Hold grid, registers and rule logic
    llca_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .func      (func),
        .row       (row),
        .col       (col),
        .cell_in   (cell_in),
        .cmd       (cmd),
        .status    (status),
        .valid     (valid),
        .cell_out  (cell_out),
        .done_res  (done_res)
    );

endmodule
